// ===== rtl/core/ezr_pkg.sv =====
// Package for the Euler ZYX to rotation matrix block.
// Holds fixed-point constants, the CORDIC arctangent table and the pipeline word type.
// No dependencies.
package ezr_pkg;

  localparam int ANGLE_W      = 17;
  localparam int OUT_W        = 32;
  localparam int FRAC_BITS_DEF = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd36000;
  localparam logic [16:0] QUARTER_TURN = 17'd9000;
  localparam logic [27:0] CDEG_TO_RAD_Q40 = 28'd191900981;
  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] ONE_Q30 = 34'sh040000000;

  typedef logic signed [CW-1:0] fix_t;

  function automatic fix_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sh03243F6A8;
      5'd1: atan_q30 = 34'sh01DAC6705;
      5'd2: atan_q30 = 34'sh00FADBAFC;
      5'd3: atan_q30 = 34'sh007F56EA6;
      5'd4: atan_q30 = 34'sh003FEAB76;
      5'd5: atan_q30 = 34'sh001FFD55B;
      5'd6: atan_q30 = 34'sh000FFFAAA;
      5'd7: atan_q30 = 34'sh0007FFF55;
      5'd8: atan_q30 = 34'sh0003FFFEA;
      5'd9: atan_q30 = 34'sh0001FFFFD;
      default: atan_q30 = fix_t'((64'sd1 <<< (30 - i)) - 64'sd1);
    endcase
  endfunction

  function automatic fix_t clamp_one(input fix_t v);
    if (v > ONE_Q30) clamp_one = ONE_Q30;
    else if (v < -ONE_Q30) clamp_one = -ONE_Q30;
    else clamp_one = v;
  endfunction

  // Q30 product, round half up then floor
  function automatic fix_t qmul(input fix_t a, input fix_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    qmul = fix_t'(p >>> 30);
  endfunction

endpackage

// ===== rtl/core/euler_zyx_to_rotation_matrix.sv =====
// Top level: Euler ZYX angles to 3x3 rotation matrix, Q1.FRAC_BITS.
// One word accepted every cycle, busy stays low; path: sincos, p1, p2, output regs.
// Reset (rst, synchronous) clears the valid pipeline only; no other state.
// Depends on ezr_pkg and ezr_sincos.
module euler_zyx_to_rotation_matrix #(
  parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_first_cdeg,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_second_cdeg,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_third_cdeg,
  output logic                              done,
  output logic signed [ezr_pkg::OUT_W-1:0]  m00,
  output logic signed [ezr_pkg::OUT_W-1:0]  m01,
  output logic signed [ezr_pkg::OUT_W-1:0]  m02,
  output logic signed [ezr_pkg::OUT_W-1:0]  m10,
  output logic signed [ezr_pkg::OUT_W-1:0]  m11,
  output logic signed [ezr_pkg::OUT_W-1:0]  m12,
  output logic signed [ezr_pkg::OUT_W-1:0]  m20,
  output logic signed [ezr_pkg::OUT_W-1:0]  m21,
  output logic signed [ezr_pkg::OUT_W-1:0]  m22
);
  import ezr_pkg::*;

  localparam int SH = 30 - FRAC_BITS;

  assign busy = 1'b0;

  logic va, vb, vc;
  fix_t sa, ka, sb, kb, sc, kc;

  ezr_sincos u_a (.clk, .rst, .in_valid(start), .angle(angle_first_cdeg),
                  .out_valid(va), .sin_q(sa), .cos_q(ka));
  ezr_sincos u_b (.clk, .rst, .in_valid(start), .angle(angle_second_cdeg),
                  .out_valid(vb), .sin_q(sb), .cos_q(kb));
  ezr_sincos u_c (.clk, .rst, .in_valid(start), .angle(angle_third_cdeg),
                  .out_valid(vc), .sin_q(sc), .cos_q(kc));

  // stage p1: first products
  logic p1v;
  fix_t sbsa, sbka, kckb, sckb, kbsa, kbka, scka, scsa, kcka, kcsa, nsb;
  fix_t kc1, sc1;
  always_ff @(posedge clk) begin
    if (rst) p1v <= 1'b0;
    else p1v <= va & vb & vc;
    sbsa <= qmul(sb, sa); sbka <= qmul(sb, ka);
    kckb <= qmul(kc, kb); sckb <= qmul(sc, kb);
    kbsa <= qmul(kb, sa); kbka <= qmul(kb, ka);
    scka <= qmul(sc, ka); scsa <= qmul(sc, sa);
    kcka <= qmul(kc, ka); kcsa <= qmul(kc, sa);
    nsb <= -sb; kc1 <= kc; sc1 <= sc;
  end

  // stage p2: second products and sums
  logic p2v;
  fix_t e [9];
  always_ff @(posedge clk) begin
    if (rst) p2v <= 1'b0;
    else p2v <= p1v;
    e[0] <= kckb;
    e[1] <= qmul(kc1, sbsa) - scka;
    e[2] <= qmul(kc1, sbka) + scsa;
    e[3] <= sckb;
    e[4] <= qmul(sc1, sbsa) + kcka;
    e[5] <= qmul(sc1, sbka) - kcsa;
    e[6] <= nsb;
    e[7] <= kbsa;
    e[8] <= kbka;
  end

  function automatic logic signed [OUT_W-1:0] to_out(input fix_t v);
    fix_t c;
    c = clamp_one(v);
    if (SH > 0) c = (c + (fix_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    to_out = OUT_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= p2v;
    m00 <= to_out(e[0]); m01 <= to_out(e[1]); m02 <= to_out(e[2]);
    m10 <= to_out(e[3]); m11 <= to_out(e[4]); m12 <= to_out(e[5]);
    m20 <= to_out(e[6]); m21 <= to_out(e[7]); m22 <= to_out(e[8]);
  end
endmodule

// ===== rtl/core/ezr_sincos.sv =====
// Pipelined sine/cosine of one angle in hundredths of a degree.
// Fold, radian conversion, 30 CORDIC stages, quadrant fixup. Depends on ezr_pkg.
module ezr_sincos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle,
  output logic                              out_valid,
  output ezr_pkg::fix_t                     sin_q,
  output ezr_pkg::fix_t                     cos_q
);
  import ezr_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [ANGLE_W-1:0] a_sat;
  logic [16:0] a_fold;
  logic [1:0]  quad_c;
  logic [16:0] rem_c;

  always_comb begin
    a_sat = angle;
    if (angle > ANGLE_LIMIT) a_sat = ANGLE_LIMIT;
    if (angle < -ANGLE_LIMIT) a_sat = -ANGLE_LIMIT;
    if (a_sat < 0) a_fold = 17'(a_sat + ANGLE_LIMIT);
    else if (a_sat >= ANGLE_LIMIT) a_fold = 17'd0;
    else a_fold = 17'(a_sat);
    if (a_fold >= 3 * QUARTER_TURN) begin
      quad_c = 2'd3; rem_c = a_fold - 17'(3 * QUARTER_TURN);
    end else if (a_fold >= 2 * QUARTER_TURN) begin
      quad_c = 2'd2; rem_c = a_fold - 17'(2 * QUARTER_TURN);
    end else if (a_fold >= QUARTER_TURN) begin
      quad_c = 2'd1; rem_c = a_fold - QUARTER_TURN;
    end else begin
      quad_c = 2'd0; rem_c = a_fold;
    end
  end

  // stage 0: folded angle
  logic v0; logic [1:0] q0; logic [13:0] r0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= in_valid;
    q0 <= quad_c;
    r0 <= rem_c[13:0];
  end

  // stage 1: radians
  logic v1; logic [1:0] q1; logic z1_zero; fix_t z1;
  logic [41:0] zprod;
  assign zprod = 42'(r0) * 42'(CDEG_TO_RAD_Q40) + 42'd512;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    q1 <= q0;
    z1_zero <= (r0 == 14'd0);
    z1 <= fix_t'(zprod >> 10);
  end

  // CORDIC stages
  fix_t xs [N+1]; fix_t ys [N+1]; fix_t zs [N+1];
  logic vs [N+1]; logic [1:0] qs [N+1]; logic zz [N+1];
  assign xs[0] = CORDIC_GAIN_INV;
  assign ys[0] = '0;
  assign zs[0] = z1;
  assign vs[0] = v1;
  assign qs[0] = q1;
  assign zz[0] = z1_zero;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    fix_t dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
      qs[i+1] <= qs[i];
      zz[i+1] <= zz[i];
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - dx; ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - atan_q30(5'(i));
      end else begin
        xs[i+1] <= xs[i] + dx; ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + atan_q30(5'(i));
      end
    end
  end

  fix_t s_c, k_c;
  always_comb begin
    if (zz[N]) begin
      s_c = '0; k_c = ONE_Q30;
    end else begin
      s_c = clamp_one(ys[N]); k_c = clamp_one(xs[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vs[N];
    case (qs[N])
      2'd0: begin sin_q <= s_c;  cos_q <= k_c;  end
      2'd1: begin sin_q <= k_c;  cos_q <= -s_c; end
      2'd2: begin sin_q <= -s_c; cos_q <= -k_c; end
      default: begin sin_q <= -k_c; cos_q <= s_c; end
    endcase
  end
endmodule

// ===== rtl/core/ezr_checker.sv =====
// Port-level checker for euler_zyx_to_rotation_matrix, bound to the top level.
// Depends on ezr_pkg.
module ezr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic signed [ezr_pkg::OUT_W-1:0] m00,
  input logic signed [ezr_pkg::OUT_W-1:0] m20,
  input logic signed [ezr_pkg::OUT_W-1:0] m22
);
  import ezr_pkg::*;

  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_rst_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 36)) else $error("done without start");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (m00 <= 32'sh40000000 && m00 >= -32'sh40000000 &&
              m20 <= 32'sh40000000 && m22 >= -32'sh40000000))
    else $error("entry out of range");
endmodule

bind euler_zyx_to_rotation_matrix ezr_checker u_ezr_checker (
  .clk, .rst, .start, .busy, .done, .m00, .m20, .m22
);

// ===== test/tb_euler_zyx_to_rotation_matrix.sv =====
// Testbench for euler_zyx_to_rotation_matrix: random and corner-case angle words,
// a predictor of the CORDIC sine/cosine and matrix math, in-order result checks.
// Depends on ezr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_euler_zyx_to_rotation_matrix;

  localparam int FRAC = ezr_pkg::FRAC_BITS_DEF;
  localparam int PIPE_WAIT = 60;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [31:0] m [9];
  } matrix_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic signed [16:0] angle_first_cdeg = '0, angle_second_cdeg = '0, angle_third_cdeg = '0;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t expected_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  euler_zyx_to_rotation_matrix #(.FRAC_BITS(FRAC)) DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp1(longint v);
    if (v > (64'sd1 << 30)) return 64'sd1 << 30;
    if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
    return v;
  endfunction

  function automatic longint mulq30(longint a, longint b);
    return fshift(a * b + (64'sd1 << 29), 30);
  endfunction

  function automatic longint arctan_step(int i);
    longint t [10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                       64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                       64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return t[i];
    return (64'sd1 << (30 - i)) - 1;
  endfunction

  task automatic sine_cosine(input logic signed [16:0] ang, output longint s_o,
                             output longint c_o);
    longint a, r, s, c, x, y, z, dx, dy;
    int quad;
    a = ang;
    if (a > 36000) a = 36000;
    if (a < -36000) a = -36000;
    if (a < 0) a += 36000;
    if (a >= 36000) a -= 36000;
    quad = a / 9000;
    r = a % 9000;
    if (r == 0) begin
      s = 0;
      c = 64'sd1 << 30;
    end else begin
      x = 64'h26DD3B6A;
      y = 0;
      z = fshift(r * 191900981 + 512, 10);
      for (int i = 0; i < 30; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_step(i);
        end else begin
          x += dx; y -= dy; z += arctan_step(i);
        end
      end
      s = clamp1(y);
      c = clamp1(x);
    end
    case (quad)
      0: begin s_o = s; c_o = c; end
      1: begin s_o = c; c_o = -s; end
      2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endtask

  function automatic logic signed [31:0] scale_entry(longint v);
    v = clamp1(v);
    if (FRAC < 30) v = fshift(v + (64'sd1 << (29 - FRAC)), 30 - FRAC);
    return v[31:0];
  endfunction

  task automatic predict_matrix(input logic signed [16:0] a1, a2, a3, output matrix_t r);
    longint sa, ka, sb, kb, sc, kc, sbsa, sbka;
    sine_cosine(a1, sa, ka);
    sine_cosine(a2, sb, kb);
    sine_cosine(a3, sc, kc);
    sbsa = mulq30(sb, sa);
    sbka = mulq30(sb, ka);
    r.m[0] = scale_entry(mulq30(kc, kb));
    r.m[1] = scale_entry(mulq30(kc, sbsa) - mulq30(sc, ka));
    r.m[2] = scale_entry(mulq30(kc, sbka) + mulq30(sc, sa));
    r.m[3] = scale_entry(mulq30(sc, kb));
    r.m[4] = scale_entry(mulq30(sc, sbsa) + mulq30(kc, ka));
    r.m[5] = scale_entry(mulq30(sc, sbka) - mulq30(kc, sa));
    r.m[6] = scale_entry(-sb);
    r.m[7] = scale_entry(mulq30(kb, sa));
    r.m[8] = scale_entry(mulq30(kb, ka));
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // one word per call; random idle cycles before it
  task automatic send_angles(input logic signed [16:0] a1, a2, a3);
    matrix_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    angle_first_cdeg <= a1;
    angle_second_cdeg <= a2;
    angle_third_cdeg <= a3;
    predict_matrix(a1, a2, a3, e);
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q = {expected_q, e};
  endtask

  task automatic end_burst();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(9))
      0: return 17'($urandom);
      1: return 17'($urandom_range(8)) * 17'sd4500 - 17'sd18000;
      default: return 17'($urandom_range(72000)) - 17'sd36000;
    endcase
  endfunction

  always @(posedge clk) begin
    matrix_t e;
    logic signed [31:0] got [9];
    if (!rst && done) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (expected_q.size() == 0) report_mismatch("matrix word with none expected");
      else begin
        e = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.m[i])
            report_mismatch($sformatf("m%0d%0d got %0d exp %0d",
                                      i / 3, i % 3, got[i], e.m[i]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [16:0] corner [14] = '{17'sd0, 17'sd36000, -17'sd36000, 17'sd9000,
                                        17'sd18000, 17'sd27000, -17'sd9000, 17'sd1,
                                        -17'sd1, 17'sd4500, 17'sd65535, 17'sh10000,
                                        17'sd35999, 17'sd8999};
    for (int i = 0; i < 14; i++)
      send_angles(corner[i], corner[(i + 3) % 14], corner[(i + 7) % 14]);
    send_angles(17'sd3000, 17'sd9000, 17'sd4500);
    send_angles(17'sd3000, -17'sd9000, 17'sd4500);
    send_angles(17'sd65535, 17'sd65535, 17'sd65535);
    send_angles(17'sh10000, 17'sh10000, 17'sh10000);
    end_burst();
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    end_burst();
  endtask

  task automatic test_drain_and_resume();
    while (expected_q.size() != 0) @(posedge clk);
    test_random(20, 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(230, 26);
    test_drain_and_resume();
    test_random(230, 64);
    test_random(230, 0);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
